### hw/rtl/itra_pkg.sv
// Shared types, character codes and the digit glyph lookup for the radix formatter.
package itra_pkg;

	typedef logic [3:0] digit_t;
	typedef logic [7:0] char_t;

	localparam char_t CHAR_ZERO  = 8'h30;
	localparam char_t CHAR_A     = 8'h61;
	localparam char_t CHAR_X     = 8'h78;
	localparam char_t CHAR_MINUS = 8'h2d;

	localparam logic [4:0] RADIX_RESET = 5'd10;
	localparam logic [4:0] RADIX_MIN   = 5'd2;
	localparam logic [4:0] RADIX_OCT   = 5'd8;
	localparam logic [4:0] RADIX_HEX   = 5'd16;
	localparam logic [4:0] RADIX_MAX   = 5'd16;

	localparam int CHUNK_BITS = 8;

	// Digit stack commands from the sequencer
	typedef struct packed {
		logic push;
		logic pop;
	} stk_ctrl_t;

	function automatic char_t digit_glyph(input digit_t d);
		char_t g;
		if (d < 4'd10) begin
			g = CHAR_ZERO + {4'd0, d};
		end else begin
			g = CHAR_A + {4'd0, d} - 8'd10;
		end
		return g;
	endfunction

endpackage

### hw/rtl/itra_divstep.sv
// Shared divide unit: eight restoring steps of one chunk of a word by a small base per cycle.
module itra_divstep
	import itra_pkg::*;
(
	input  logic [4:0]            base,
	input  digit_t                rem_in,
	input  logic [CHUNK_BITS-1:0] chunk,
	output logic [CHUNK_BITS-1:0] quo,
	output digit_t                rem_out
);

	always_comb begin
		logic [4:0] r;
		r = {1'b0, rem_in};
		quo = '0;
		for (int i = CHUNK_BITS - 1; i >= 0; i--) begin
			r = {r[3:0], chunk[i]};
			if (r >= base) begin
				r = r - base;
				quo[i] = 1'b1;
			end
		end
		rem_out = r[3:0];
	end

endmodule

### hw/rtl/itra_digit_stack.sv
// Digit stack: digits pushed least significant first, popped most significant first.
module itra_digit_stack
	import itra_pkg::*;
#(
	parameter int DEPTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  stk_ctrl_t ctrl,
	input  digit_t    push_data,
	output digit_t    rd_data,
	output logic      empty
);

	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	digit_t          mem [DEPTH];
	logic [CNTW-1:0] count_q;

	assign empty = (count_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.push) begin
			count_q <= count_q + 1'b1;
		end else if (ctrl.pop) begin
			count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			mem[count_q[AW-1:0]] <= push_data;
		end
		if (ctrl.pop) begin
			rd_data <= mem[AW'(count_q - 1'b1)];
		end
	end

endmodule

### hw/rtl/integer_to_radix_ascii.sv
// Top level: formats a signed integer as ASCII text in a configured base.
//
// Usage
//   radix_we/radix_wdata write the base (2..16, saturated; reset 10) while idle.
//   A word on item_valid/value is taken when item_stall is low. The text goes
//   out on char_valid/ascii_char/last, one character per beat, most
//   significant first: optional '-', "0x" (base 16) or "0" (base 8), digits.
// Timing
//   The magnitude is divided by the base in one shared unit, eight bits per
//   cycle, one pass over all of its chunks per digit until the quotient is
//   zero. The sign and prefix characters are then loaded, and each digit
//   takes a stack read, then an output load; every output load waits on
//   char_stall. item_stall is high throughout an item.
// Reset
//   arst_n clears the sequencer, output valid and the digit stack count.
// Back-pressure
//   char_stall holds the output register; the sequencer waits on it and
//   loses nothing. A new item may be taken while the final character waits.
module integer_to_radix_ascii
	import itra_pkg::*;
#(
	parameter int VALUE_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               radix_we,
	input  logic [4:0]         radix_wdata,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic signed [31:0] value,
	output logic               char_valid,
	input  logic               char_stall,
	output logic [7:0]         ascii_char,
	output logic               last
);

	localparam int CHUNKS = (VALUE_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
	localparam int DW     = CHUNKS * CHUNK_BITS;
	localparam int CW     = $clog2(CHUNKS + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV  = 3'd1;
	localparam logic [2:0] S_SIGN = 3'd2;
	localparam logic [2:0] S_PRE0 = 3'd3;
	localparam logic [2:0] S_PREX = 3'd4;
	localparam logic [2:0] S_RD   = 3'd5;
	localparam logic [2:0] S_DIG  = 3'd6;

	logic [2:0]  state_q;
	logic [4:0]  radix_q;
	logic [4:0]  base_q;
	logic        neg_q;
	logic [DW-1:0] mag_q;
	digit_t      rem_q;
	logic [CW-1:0] cnt_q;
	logic        nz_q;
	logic        char_valid_q;
	char_t       char_q;
	logic        last_q;

	logic signed [VALUE_BITS-1:0] raw;
	logic [VALUE_BITS-1:0]        mag_in;
	logic [4:0]                   base_in;
	logic                         accept;
	logic                         load_ok;
	logic [CHUNK_BITS-1:0]        quo;
	digit_t                       rem_next;
	logic                         chunk_last;
	logic                         more;
	stk_ctrl_t                    stk_ctrl;
	digit_t                       stk_rd;
	logic                         stk_empty;
	logic                         has_prefix;

	assign raw     = VALUE_BITS'(value);
	assign mag_in  = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
	assign base_in = (radix_q < RADIX_MIN) ? RADIX_MIN :
	                 (radix_q > RADIX_MAX) ? RADIX_MAX : radix_q;

	assign item_stall = (state_q != S_IDLE);
	assign accept     = item_valid && !item_stall;
	assign load_ok    = !char_valid_q || !char_stall;
	assign has_prefix = (base_q == RADIX_HEX) || (base_q == RADIX_OCT);

	assign chunk_last = (cnt_q == CW'(CHUNKS - 1));
	assign more       = nz_q || (|quo);

	itra_divstep u_divstep (
		.base    (base_q),
		.rem_in  (rem_q),
		.chunk   (mag_q[DW-1 -: CHUNK_BITS]),
		.quo     (quo),
		.rem_out (rem_next)
	);

	always_comb begin
		stk_ctrl.push = (state_q == S_DIV) && chunk_last;
		stk_ctrl.pop  = (state_q == S_RD);
	end

	itra_digit_stack #(
		.DEPTH (VALUE_BITS)
	) u_stack (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (stk_ctrl),
		.push_data (rem_next),
		.rd_data   (stk_rd),
		.empty     (stk_empty)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (radix_we) begin
			radix_q <= radix_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) state_q <= S_DIV;
				end
				S_DIV: begin
					if (chunk_last && !more) begin
						if (neg_q) state_q <= S_SIGN;
						else if (has_prefix) state_q <= S_PRE0;
						else state_q <= S_RD;
					end
				end
				S_SIGN: begin
					if (load_ok) state_q <= has_prefix ? S_PRE0 : S_RD;
				end
				S_PRE0: begin
					if (load_ok) state_q <= (base_q == RADIX_HEX) ? S_PREX : S_RD;
				end
				S_PREX: begin
					if (load_ok) state_q <= S_RD;
				end
				S_RD: begin
					state_q <= S_DIG;
				end
				S_DIG: begin
					if (load_ok) state_q <= stk_empty ? S_IDLE : S_RD;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Divide datapath: quotient bits shift in at the bottom as chunks leave the top
	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q  <= DW'(mag_in);
			neg_q  <= raw[VALUE_BITS-1];
			base_q <= base_in;
			rem_q  <= '0;
			cnt_q  <= '0;
			nz_q   <= 1'b0;
		end else if (state_q == S_DIV) begin
			mag_q <= (mag_q << CHUNK_BITS) | DW'(quo);
			if (chunk_last) begin
				rem_q <= '0;
				cnt_q <= '0;
				nz_q  <= 1'b0;
			end else begin
				rem_q <= rem_next;
				cnt_q <= cnt_q + 1'b1;
				nz_q  <= more;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_valid_q <= 1'b0;
		end else if (load_ok && ((state_q == S_SIGN) || (state_q == S_PRE0) ||
		                         (state_q == S_PREX) || (state_q == S_DIG))) begin
			char_valid_q <= 1'b1;
		end else if (!char_stall) begin
			char_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_ok) begin
			unique case (state_q)
				S_SIGN: begin
					char_q <= CHAR_MINUS;
					last_q <= 1'b0;
				end
				S_PRE0: begin
					char_q <= CHAR_ZERO;
					last_q <= 1'b0;
				end
				S_PREX: begin
					char_q <= CHAR_X;
					last_q <= 1'b0;
				end
				S_DIG: begin
					char_q <= digit_glyph(stk_rd);
					last_q <= stk_empty;
				end
				default: begin
					char_q <= char_q;
					last_q <= last_q;
				end
			endcase
		end
	end

	assign char_valid = char_valid_q;
	assign ascii_char = char_q;
	assign last       = last_q;

`ifndef NO_ASSERTIONS
	// Every digit has left the digit stack by the time a new word can be taken
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!item_stall |-> stk_empty)
		else $error("digit stack not empty while idle");

	a_push_pop: assert property (@(posedge clk) disable iff (!arst_n)
		!(stk_ctrl.push && stk_ctrl.pop))
		else $error("digit stack pushed and popped together");

	a_base_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (base_q >= RADIX_MIN) && (base_q <= RADIX_MAX))
		else $error("divide base out of range");

	// A digit load follows its stack read directly
	a_rd_then_dig: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD) |=> (state_q == S_DIG))
		else $error("stack read not followed by digit load");
`endif

endmodule
